// ===== src/matrix_stack_transform_engine_defines.svh =====
// assertion macros shared by the checker
`ifndef MATRIX_STACK_TRANSFORM_ENGINE_DEFINES_SVH
`define MATRIX_STACK_TRANSFORM_ENGINE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define MSTE_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mste assertion failed");

// next-cycle implication, checked outside reset
`define MSTE_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mste assertion failed");

`endif

// ===== src/mste_pkg.sv =====
`default_nettype none
package mste_pkg;

    localparam int STACK_DEPTH = 16;
    localparam int FRAC_BITS   = 16;
    localparam int LVL_W       = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int ADDR_W      = LVL_W + 4;
    localparam int MEM_DEPTH   = STACK_DEPTH * 16;
    localparam int ACC_W       = 68;

    typedef logic signed [ACC_W-1:0] t_acc;
    typedef logic [LVL_W-1:0]        t_lvl;
    typedef logic [ADDR_W-1:0]       t_addr;

    localparam t_acc ACC_HALF = t_acc'(1) <<< (FRAC_BITS - 1);
    localparam t_acc SAT_HI   = t_acc'(64'sh0000_0000_7fff_ffff);
    localparam t_acc SAT_LO   = t_acc'(-64'sh0000_0000_8000_0000);
    localparam t_lvl LVL_FULL = t_lvl'(STACK_DEPTH - 1);

    typedef enum logic [2:0] {
        OP_PUSH  = 3'd0,
        OP_POP   = 3'd1,
        OP_LOAD  = 3'd2,
        OP_MULT  = 3'd3,
        OP_PLOAD = 3'd4,
        OP_PMULT = 3'd5,
        OP_XFORM = 3'd6,
        OP_READ  = 3'd7
    } t_op;

    typedef enum logic [3:0] {
        S_IDLE,
        S_COPY_RD,
        S_COPY_WR,
        S_LOAD_WR,
        S_COL_RD,
        S_COL_LD,
        S_MUL,
        S_ADD,
        S_STORE,
        S_ROW_RD,
        S_ROW_LD,
        S_DONE
    } t_state;

endpackage
`default_nettype wire

// ===== src/mste_in_if.sv =====
`default_nettype none
interface mste_in_if;
    logic               valid;
    logic               ready;
    logic [2:0]         operation;
    logic [1:0]         row;
    logic signed [31:0] a0;
    logic signed [31:0] a1;
    logic signed [31:0] a2;
    logic signed [31:0] a3;

    modport source (output valid, operation, row, a0, a1, a2, a3, input ready);
    modport sink   (input valid, operation, row, a0, a1, a2, a3, output ready);
endinterface
`default_nettype wire

// ===== src/mste_out_if.sv =====
`default_nettype none
interface mste_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] r0;
    logic signed [31:0] r1;
    logic signed [31:0] r2;
    logic signed [31:0] r3;
    logic               refused;
    logic [3:0]         level;

    modport source (output valid, r0, r1, r2, r3, refused, level, input ready);
    modport sink   (input valid, r0, r1, r2, r3, refused, level, output ready);
endinterface
`default_nettype wire

// ===== src/matrix_stack_transform_engine.sv =====
// throughput: one transaction at a time, set by the single 32x32 multiplier and
// the one read and one write port of the stack memory
// reset: synchronous active-low i_rst_n clears the level, sequencer and output valid;
// stack and staging contents stay undefined until written
`default_nettype none
module matrix_stack_transform_engine (
    input  wire          i_clk,
    input  wire          i_rst_n,
    mste_in_if.sink      i_in,
    mste_out_if.source   o_out
);

    mste_pkg::t_state r_state, n_state;

    // stack memory
    logic signed [31:0] r_mem [mste_pkg::MEM_DEPTH];
    logic signed [31:0] r_rd_data;
    logic               mem_we;
    mste_pkg::t_addr    mem_wa;
    logic signed [31:0] mem_wd;
    mste_pkg::t_addr    rd_addr;

    // item and working registers
    mste_pkg::t_op      r_op;
    logic [1:0]         r_row;
    logic signed [31:0] r_a     [3];
    logic signed [31:0] r_stage [16];
    logic signed [31:0] r_col   [4];
    logic signed [31:0] r_res   [4];
    mste_pkg::t_lvl     r_lvl, r_dst_lvl;
    logic [3:0]         r_e;
    logic [1:0]         r_i, r_j, r_k;
    logic signed [63:0] r_prod;
    mste_pkg::t_acc     r_acc;
    logic               r_refused;
    logic               r_out_valid;

    logic               acc_in;
    logic               full;
    mste_pkg::t_op      in_op;
    logic               row_op;
    logic               commit;
    logic [1:0]         k_last;
    logic signed [31:0] mul_a;
    mste_pkg::t_acc     bias;
    mste_pkg::t_acc     rounded;
    logic signed [31:0] sat_val;

    assign i_in.ready    = (r_state == mste_pkg::S_IDLE) && !r_out_valid;
    assign acc_in        = i_in.valid && i_in.ready;
    assign full          = (r_lvl == mste_pkg::LVL_FULL);
    assign in_op         = mste_pkg::t_op'(i_in.operation);
    assign row_op        = (in_op == mste_pkg::OP_LOAD) || (in_op == mste_pkg::OP_MULT) ||
                           (in_op == mste_pkg::OP_PLOAD) || (in_op == mste_pkg::OP_PMULT);
    assign commit        = row_op && (i_in.row == 2'd3);
    assign k_last        = (r_op == mste_pkg::OP_XFORM) ? 2'd2 : 2'd3;
    assign mul_a         = (r_op == mste_pkg::OP_XFORM) ? r_a[r_k] : r_stage[{r_i, r_k}];
    assign bias          = (r_op == mste_pkg::OP_XFORM) ? mste_pkg::t_acc'(r_col[3]) : '0;

    // round half up, add translation (transform only), saturate
    assign rounded = ((r_acc + mste_pkg::ACC_HALF) >>> mste_pkg::FRAC_BITS) + bias;
    always_comb begin
        if (rounded > mste_pkg::SAT_HI) begin
            sat_val = 32'sh7fff_ffff;
        end else if (rounded < mste_pkg::SAT_LO) begin
            sat_val = -32'sh8000_0000;
        end else begin
            sat_val = rounded[31:0];
        end
    end

    // output port
    assign o_out.valid   = r_out_valid;
    assign o_out.r0      = r_res[0];
    assign o_out.r1      = r_res[1];
    assign o_out.r2      = r_res[2];
    assign o_out.r3      = r_res[3];
    assign o_out.refused = r_refused;
    assign o_out.level   = 4'(r_lvl);

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mste_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // sequencer: next state and memory controls
    always_comb begin
        n_state = r_state;
        mem_we  = 1'b0;
        mem_wa  = {r_dst_lvl, r_e};
        mem_wd  = r_rd_data;
        rd_addr = {r_lvl, r_e};
        unique case (r_state)
            mste_pkg::S_IDLE: begin
                if (acc_in) begin
                    if (in_op == mste_pkg::OP_PUSH) begin
                        n_state = full ? mste_pkg::S_DONE : mste_pkg::S_COPY_RD;
                    end else if (in_op == mste_pkg::OP_XFORM) begin
                        n_state = mste_pkg::S_COL_RD;
                    end else if (in_op == mste_pkg::OP_READ) begin
                        n_state = mste_pkg::S_ROW_RD;
                    end else if (!commit) begin
                        n_state = mste_pkg::S_DONE;
                    end else if (in_op == mste_pkg::OP_LOAD) begin
                        n_state = mste_pkg::S_LOAD_WR;
                    end else if (in_op == mste_pkg::OP_MULT) begin
                        n_state = mste_pkg::S_COL_RD;
                    end else if (full) begin
                        n_state = mste_pkg::S_DONE;
                    end else if (in_op == mste_pkg::OP_PLOAD) begin
                        n_state = mste_pkg::S_LOAD_WR;
                    end else begin
                        n_state = mste_pkg::S_COL_RD;
                    end
                end
            end
            mste_pkg::S_COPY_RD: begin
                n_state = mste_pkg::S_COPY_WR;
            end
            mste_pkg::S_COPY_WR: begin
                mem_we  = 1'b1;
                n_state = (r_e == 4'd15) ? mste_pkg::S_DONE : mste_pkg::S_COPY_RD;
            end
            mste_pkg::S_LOAD_WR: begin
                mem_we  = 1'b1;
                mem_wd  = r_stage[r_e];
                n_state = (r_e == 4'd15) ? mste_pkg::S_DONE : mste_pkg::S_LOAD_WR;
            end
            mste_pkg::S_COL_RD: begin
                rd_addr = {r_lvl, r_k, r_j};
                n_state = mste_pkg::S_COL_LD;
            end
            mste_pkg::S_COL_LD: begin
                n_state = (r_k == 2'd3) ? mste_pkg::S_MUL : mste_pkg::S_COL_RD;
            end
            mste_pkg::S_MUL: begin
                n_state = mste_pkg::S_ADD;
            end
            mste_pkg::S_ADD: begin
                n_state = (r_k == k_last) ? mste_pkg::S_STORE : mste_pkg::S_MUL;
            end
            mste_pkg::S_STORE: begin
                if (r_op == mste_pkg::OP_XFORM) begin
                    n_state = (r_j == 2'd3) ? mste_pkg::S_DONE : mste_pkg::S_COL_RD;
                end else begin
                    mem_we = 1'b1;
                    mem_wa = {r_dst_lvl, r_i, r_j};
                    mem_wd = sat_val;
                    if (r_i != 2'd3) begin
                        n_state = mste_pkg::S_MUL;
                    end else begin
                        n_state = (r_j == 2'd3) ? mste_pkg::S_DONE : mste_pkg::S_COL_RD;
                    end
                end
            end
            mste_pkg::S_ROW_RD: begin
                rd_addr = {r_lvl, r_row, r_k};
                n_state = mste_pkg::S_ROW_LD;
            end
            mste_pkg::S_ROW_LD: begin
                n_state = (r_k == 2'd3) ? mste_pkg::S_DONE : mste_pkg::S_ROW_RD;
            end
            mste_pkg::S_DONE: begin
                n_state = mste_pkg::S_IDLE;
            end
            default: begin
                n_state = mste_pkg::S_IDLE;
            end
        endcase
    end

    // memory write and registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lvl       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == mste_pkg::S_DONE) begin
                r_lvl       <= r_dst_lvl;
                r_out_valid <= 1'b1;
            end else if (o_out.valid && o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            mste_pkg::S_IDLE: begin
                if (acc_in) begin
                    r_op      <= in_op;
                    r_row     <= i_in.row;
                    r_a[0]    <= i_in.a0;
                    r_a[1]    <= i_in.a1;
                    r_a[2]    <= i_in.a2;
                    r_e       <= '0;
                    r_i       <= '0;
                    r_j       <= '0;
                    r_k       <= '0;
                    r_acc     <= '0;
                    for (int n = 0; n < 4; n++) begin
                        r_res[n] <= '0;
                    end
                    r_refused <= full && ((in_op == mste_pkg::OP_PUSH) ||
                                 (commit && ((in_op == mste_pkg::OP_PLOAD) ||
                                             (in_op == mste_pkg::OP_PMULT))));
                    r_dst_lvl <= r_lvl;
                    if (!full && ((in_op == mste_pkg::OP_PUSH) ||
                        (commit && ((in_op == mste_pkg::OP_PLOAD) ||
                                    (in_op == mste_pkg::OP_PMULT))))) begin
                        r_dst_lvl <= r_lvl + 1'b1;
                    end else if ((in_op == mste_pkg::OP_POP) && (r_lvl != '0)) begin
                        r_dst_lvl <= r_lvl - 1'b1;
                    end
                    if (row_op) begin
                        r_stage[{i_in.row, 2'd0}] <= i_in.a0;
                        r_stage[{i_in.row, 2'd1}] <= i_in.a1;
                        r_stage[{i_in.row, 2'd2}] <= i_in.a2;
                        r_stage[{i_in.row, 2'd3}] <= i_in.a3;
                    end
                end
            end
            mste_pkg::S_COPY_WR, mste_pkg::S_LOAD_WR: begin
                r_e <= r_e + 1'b1;
            end
            mste_pkg::S_COL_LD: begin
                r_col[r_k] <= r_rd_data;
                r_k        <= r_k + 1'b1;
                if (r_k == 2'd3) begin
                    r_i   <= '0;
                    r_acc <= '0;
                end
            end
            mste_pkg::S_MUL: begin
                r_prod <= mul_a * r_col[r_k];
            end
            mste_pkg::S_ADD: begin
                r_acc <= r_acc + mste_pkg::t_acc'(r_prod);
                r_k   <= r_k + 1'b1;
            end
            mste_pkg::S_STORE: begin
                r_k   <= '0;
                r_acc <= '0;
                if (r_op == mste_pkg::OP_XFORM) begin
                    r_res[r_j] <= sat_val;
                    r_j        <= r_j + 1'b1;
                end else begin
                    r_i <= r_i + 1'b1;
                    if (r_i == 2'd3) begin
                        r_j <= r_j + 1'b1;
                    end
                end
            end
            mste_pkg::S_ROW_LD: begin
                r_res[r_k] <= r_rd_data;
                r_k        <= r_k + 1'b1;
            end
            default: begin
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== src/mste_checker.sv =====
`default_nettype none
`include "matrix_stack_transform_engine_defines.svh"
module mste_checker (
    input wire       i_clk,
    input wire       i_rst_n,
    input wire       i_in_valid,
    input wire       i_in_ready,
    input wire       i_out_valid,
    input wire       i_out_ready,
    input wire       i_refused,
    input wire [3:0] i_level
);

    // busy right after taking a transaction
    `MSTE_ASSERT_NXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && i_in_ready, !i_in_ready)
    // no new transaction while a result waits
    `MSTE_ASSERT_IMP(a_no_accept_pending, i_clk, i_rst_n, i_out_valid, !i_in_ready)
    // a stalled result stays offered
    `MSTE_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid)
    // refusal only at the full level
    `MSTE_ASSERT_IMP(a_refused_full, i_clk, i_rst_n, i_out_valid && i_refused,
        i_level == 4'(mste_pkg::STACK_DEPTH - 1))

endmodule

bind matrix_stack_transform_engine mste_checker u_mste_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_refused   (o_out.refused),
    .i_level     (o_out.level)
);
`default_nettype wire
